// ===== rtl/wwac_pkg.sv =====
// shared types and constants of the weighted window abs contrast filter
// no dependencies; every other file but wwac_ram uses this package
package wwac_pkg;

    localparam int PIX_W      = 8;
    localparam int LEN_CFG_W  = 11;
    localparam int PACK_W     = 64;
    localparam int NPACK      = 7;
    localparam int PACK_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CONTRAST_W = 22;
    localparam int PROD_W     = 16;
    localparam int PROD_MAX   = 255 * 255;

    localparam logic [LEN_CFG_W-1:0] LEN_RESET = 11'd1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH,
        CFG_WEIGHT_PACK_0,
        CFG_WEIGHT_PACK_1,
        CFG_WEIGHT_PACK_2,
        CFG_WEIGHT_PACK_3,
        CFG_WEIGHT_PACK_4,
        CFG_WEIGHT_PACK_5,
        CFG_WEIGHT_PACK_6
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_beat;

    typedef struct packed {
        logic [CONTRAST_W-1:0] contrast;
        logic                  line_end;
    } t_res_beat;

    // column stage to window stage
    typedef struct packed {
        logic shift;
        logic emit;
        logic line_end;
    } t_s1_tag;

    // tag of a beat that will produce a result
    typedef struct packed {
        logic valid;
        logic line_end;
    } t_res_tag;

endpackage

// ===== rtl/wwac_if.sv =====
// valid/ready stream interfaces for pixel and result beats
// depends on wwac_pkg
interface wwac_pix_if;
    logic                 valid;
    logic                 ready;
    wwac_pkg::t_pix_beat  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wwac_res_if;
    logic                 valid;
    logic                 ready;
    wwac_pkg::t_res_beat  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/wwac_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module wwac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/wwac_line.sv =====
// position and line counters, line store ram and column assembly
// depends on wwac_pkg, wwac_if, wwac_ram
module wwac_line #(
    parameter int WINDOW   = 5,
    parameter int MAX_LINE = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wwac_pix_if.sink                          i_pix,
    input  logic [wwac_pkg::LEN_CFG_W-1:0]    i_line_length,
    input  logic                              i_down_ready,
    output logic [WINDOW*wwac_pkg::PIX_W-1:0] o_col,
    output wwac_pkg::t_s1_tag                 o_tag
);
    import wwac_pkg::*;

    localparam int POS_W   = $clog2(MAX_LINE);
    localparam int LEN_W   = $clog2(MAX_LINE + 1);
    localparam int LINES_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int STORE_W = (WINDOW > 1) ? PIX_W * (WINDOW - 1) : PIX_W;

    logic [POS_W-1:0]   r_pos;
    logic [LINES_W-1:0] r_lines;
    logic [POS_W-1:0]   n_pos;
    logic [LINES_W-1:0] n_lines;

    logic               en1;
    logic               acc;
    logic [LEN_W-1:0]   len;
    logic [POS_W-1:0]   pos_base;
    logic [LINES_W-1:0] lines_base;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   pos_inc;
    logic               wrap;
    logic               emit;
    logic               line_end;

    logic               r1_valid;
    logic [PIX_W-1:0]   r1_pix;
    logic [POS_W-1:0]   r1_pos;
    logic               r1_emit;
    logic               r1_line_end;
    logic               r1_byp;
    logic [STORE_W-1:0] r1_byp_data;

    logic               wr_en;
    logic [STORE_W-1:0] wr_data;
    logic [STORE_W-1:0] rd_data;
    logic [STORE_W-1:0] stored;
    logic [PIX_W-1:0]   col [WINDOW];

    assign en1         = !r1_valid || i_down_ready;
    assign i_pix.ready = en1;
    assign acc         = i_pix.valid && en1;

    // clamp of the programmed length
    always_comb begin
        if (i_line_length == '0) begin
            len = LEN_W'(1);
        end else if (32'(i_line_length) > 32'(MAX_LINE)) begin
            len = LEN_W'(MAX_LINE);
        end else begin
            len = LEN_W'(i_line_length);
        end
    end

    always_comb begin
        pos_base   = i_pix.data.frame_start ? '0 : r_pos;
        lines_base = i_pix.data.frame_start ? '0 : r_lines;
        pos        = (LEN_W'(pos_base) >= len) ? '0 : pos_base;
        pos_inc    = LEN_W'(pos) + LEN_W'(1);
        wrap       = pos_inc >= len;
        line_end   = pos_inc == len;
        emit       = (lines_base >= LINES_W'(WINDOW - 1)) && (pos >= POS_W'(WINDOW - 1));
        n_pos      = wrap ? '0 : POS_W'(pos_inc);
        n_lines    = lines_base;
        if (wrap && (lines_base < LINES_W'(WINDOW - 1))) begin
            n_lines = lines_base + LINES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_lines <= '0;
        end else if (acc) begin
            r_pos   <= n_pos;
            r_lines <= n_lines;
        end
    end

    // write back of the shifted column when the beat leaves this stage
    assign wr_en = r1_valid && i_down_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_pix.valid;
        end
    end

    // read and write of one address at one edge: forward the written column
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pix      <= i_pix.data.pixel;
            r1_pos      <= pos;
            r1_emit     <= emit;
            r1_line_end <= line_end;
            r1_byp      <= wr_en && (r1_pos == pos);
            r1_byp_data <= wr_data;
        end
    end

    wwac_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_LINE)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r1_pos),
        .i_wr_data (wr_data),
        .i_rd_en   (en1),
        .i_rd_addr (pos),
        .o_rd_data (rd_data)
    );

    assign stored = r1_byp ? r1_byp_data : rd_data;

    always_comb begin
        wr_data = '0;
        for (int r = 0; r < WINDOW - 1; r++) begin
            col[r] = stored[r*PIX_W +: PIX_W];
        end
        col[WINDOW-1] = r1_pix;
        for (int r = 0; r < WINDOW - 1; r++) begin
            wr_data[r*PIX_W +: PIX_W] = col[r+1];
        end
        for (int r = 0; r < WINDOW; r++) begin
            o_col[r*PIX_W +: PIX_W] = col[r];
        end
    end

    assign o_tag.shift    = r1_valid;
    assign o_tag.emit     = r1_emit;
    assign o_tag.line_end = r1_line_end;

`ifndef SYNTHESIS
    a_lines_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lines <= LINES_W'(WINDOW - 1))
        else $error("line counter beyond window height");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && !i_down_ready |=> r1_valid && $stable(r1_pos) && $stable(r1_pix))
        else $error("column stage lost a stalled beat");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && wrap |=> r_pos == '0)
        else $error("position did not restart after last pixel of line");
`endif
endmodule

// ===== rtl/wwac_window.sv =====
// window registers and per-tap weighted absolute differences
// depends on wwac_pkg
module wwac_window #(
    parameter int WINDOW = 5
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [WINDOW*wwac_pkg::PIX_W-1:0]          i_col,
    input  wwac_pkg::t_s1_tag                          i_tag,
    input  logic [WINDOW*WINDOW*wwac_pkg::PIX_W-1:0]   i_weights,
    input  logic                                       i_down_ready,
    output logic                                       o_up_ready,
    output logic [WINDOW*WINDOW*wwac_pkg::PROD_W-1:0]  o_prod,
    output wwac_pkg::t_res_tag                         o_tag
);
    import wwac_pkg::*;

    localparam int TAPS   = WINDOW * WINDOW;
    localparam int CENTER = (WINDOW - 1) / 2;

    logic [PIX_W-1:0]  r_win  [TAPS];
    logic [PIX_W-1:0]  n_win  [TAPS];
    logic [PROD_W-1:0] r_prod [TAPS];
    logic [PROD_W-1:0] n_prod [TAPS];
    t_res_tag          r2_tag;
    logic              en2;
    logic [PIX_W-1:0]  ctr;
    logic [PIX_W-1:0]  diff;
    logic [PIX_W-1:0]  wgt;

    assign en2        = !r2_tag.valid || i_down_ready;
    assign o_up_ready = en2;

    // window moves one position along the line, new column enters at the end
    always_comb begin
        for (int r = 0; r < WINDOW; r++) begin
            for (int c = 0; c < WINDOW - 1; c++) begin
                n_win[r*WINDOW + c] = r_win[r*WINDOW + c + 1];
            end
            n_win[r*WINDOW + WINDOW - 1] = i_col[r*PIX_W +: PIX_W];
        end
    end

    assign ctr = n_win[CENTER*WINDOW + CENTER];

    // zero taps drop out, the center counts even when zero
    always_comb begin
        diff = '0;
        wgt  = '0;
        for (int k = 0; k < TAPS; k++) begin
            diff      = (n_win[k] > ctr) ? n_win[k] - ctr : ctr - n_win[k];
            wgt       = i_weights[k*PIX_W +: PIX_W];
            n_prod[k] = (n_win[k] != '0) ? PROD_W'(diff) * PROD_W'(wgt) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
            for (int k = 0; k < TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else if (en2) begin
            r2_tag.valid    <= i_tag.shift && i_tag.emit;
            r2_tag.line_end <= i_tag.line_end;
            if (i_tag.shift) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_tag.shift) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            o_prod[k*PROD_W +: PROD_W] = r_prod[k];
        end
    end

    assign o_tag = r2_tag;
endmodule

// ===== rtl/wwac_sum.sv =====
// two level adder tree (row sums, then total) and output register
// depends on wwac_pkg, wwac_if
module wwac_sum #(
    parameter int WINDOW = 5
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [WINDOW*WINDOW*wwac_pkg::PROD_W-1:0]  i_prod,
    input  wwac_pkg::t_res_tag                         i_tag,
    output logic                                       o_up_ready,
    wwac_res_if.source                                 o_res
);
    import wwac_pkg::*;

    localparam int ROW_W = $clog2(WINDOW * PROD_MAX + 1);

    logic [ROW_W-1:0]      r3_row [WINDOW];
    logic [ROW_W-1:0]      n_row  [WINDOW];
    t_res_tag              r3_tag;
    logic [CONTRAST_W-1:0] total;
    logic                  r_o_valid;
    t_res_beat             r_o_data;
    logic                  en3;
    logic                  en_out;

    assign en_out     = !r_o_valid || o_res.ready;
    assign en3        = !r3_tag.valid || en_out;
    assign o_up_ready = en3;

    always_comb begin
        for (int r = 0; r < WINDOW; r++) begin
            n_row[r] = '0;
            for (int c = 0; c < WINDOW; c++) begin
                n_row[r] = n_row[r] + ROW_W'(i_prod[(r*WINDOW + c)*PROD_W +: PROD_W]);
            end
        end
    end

    always_comb begin
        total = '0;
        for (int r = 0; r < WINDOW; r++) begin
            total = total + CONTRAST_W'(r3_row[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (en3) begin
                r3_tag <= i_tag;
            end
            if (en_out) begin
                r_o_valid <= r3_tag.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && i_tag.valid) begin
            r3_row <= n_row;
        end
        if (en_out && r3_tag.valid) begin
            r_o_data.contrast <= total;
            r_o_data.line_end <= r3_tag.line_end;
        end
    end

    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o_data;
endmodule

// ===== rtl/weighted_window_abs_contrast.sv =====
// top level of the weighted window abs contrast filter: config registers and stage wiring
// depends on wwac_pkg, wwac_if, wwac_line, wwac_window, wwac_sum
//
// Center-surround contrast filter over a streamed 8-bit saliency map. Pixels
// enter on i_pix one per beat in memory order, a line of line_length pixels
// at a time (frame_start on a beat restarts the line and position counters
// before that pixel). Once WINDOW-1 lines and WINDOW-1 pixels of the current
// line have been seen, every further pixel produces one beat on o_res with
// the sum over the WINDOW x WINDOW window of weight[k] * |pixel[k] - center|,
// where nonzero pixels only contribute, and line_end set on the last result
// of a line. Throughput is one pixel per clock while o_res takes results; o_res
// shows the result of an accepted pixel after it passes through four register
// stages: line store read, window shift with the 8x8 tap multiplies, row
// sums, total in the output register. The line store is a single ram of
// MAX_LINE words of (WINDOW-1) pixels, read and written once per pixel,
// which is what sets the one-pixel-per-cycle rate; it has no reset and no
// clearing pass, so its content is only meaningful after the lines of the
// current frame have written it. Back pressure on o_res is absorbed by the
// empty stages first, so i_pix keeps taking beats while a result waits.
// Registers (i_cfg_idx): 0 line_length (0 reads as 1, values above MAX_LINE
// read as MAX_LINE), 1..7 weight packs, weight k in pack k/8 at bits
// 8*(k%8). Write them only while the pipeline is empty.
module weighted_window_abs_contrast #(
    parameter int WINDOW   = 5,
    parameter int MAX_LINE = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wwac_pix_if.sink                           i_pix,
    wwac_res_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [wwac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wwac_pkg::PACK_W-1:0]        i_cfg_data
);
    import wwac_pkg::*;

    localparam int TAPS = WINDOW * WINDOW;

    logic [LEN_CFG_W-1:0]      r_line_length;
    logic [PACK_W-1:0]         r_wpack [NPACK];
    logic [TAPS*PIX_W-1:0]     weights;

    // stage wiring
    logic [WINDOW*PIX_W-1:0]   col;
    t_s1_tag                   s1_tag;
    logic                      s2_ready;
    logic [TAPS*PROD_W-1:0]    prod;
    t_res_tag                  s2_tag;
    logic                      s3_ready;

    // config registers, every index past line_length is a weight pack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
            for (int p = 0; p < NPACK; p++) begin
                r_wpack[p] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LINE_LENGTH) begin
                r_line_length <= i_cfg_data[LEN_CFG_W-1:0];
            end else begin
                r_wpack[PACK_IDX_W'(i_cfg_idx - CFG_WEIGHT_PACK_0)] <= i_cfg_data;
            end
        end
    end

    // unpack the weights in window order
    for (genvar k = 0; k < TAPS; k++) begin : g_weight
        assign weights[k*PIX_W +: PIX_W] = r_wpack[k/8][(k%8)*PIX_W +: PIX_W];
    end

    wwac_line #(
        .WINDOW   (WINDOW),
        .MAX_LINE (MAX_LINE)
    ) u_line (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (i_pix),
        .i_line_length (r_line_length),
        .i_down_ready  (s2_ready),
        .o_col         (col),
        .o_tag         (s1_tag)
    );

    wwac_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_col        (col),
        .i_tag        (s1_tag),
        .i_weights    (weights),
        .i_down_ready (s3_ready),
        .o_up_ready   (s2_ready),
        .o_prod       (prod),
        .o_tag        (s2_tag)
    );

    wwac_sum #(
        .WINDOW (WINDOW)
    ) u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_prod     (prod),
        .i_tag      (s2_tag),
        .o_up_ready (s3_ready),
        .o_res      (o_res)
    );
endmodule

// ===== bench/weighted_window_abs_contrast_test.sv =====
// self-checking bench for weighted_window_abs_contrast: random pixel frames in, contrast beats checked
// depends on wwac_pkg, wwac_if and the rtl of weighted_window_abs_contrast
// expected contrast comes from an in-bench window predictor fed by every accepted pixel beat
module weighted_window_abs_contrast_test;
    import wwac_pkg::*;

    localparam int WIN          = 5;
    localparam int MAX_LINE     = 1024;
    localparam int RANDOM_BEATS = 1600;
    localparam int CALM_BEATS   = 250;   // tail of the random part runs with no idling
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;     // covers the register stages of the result path
    localparam int MAX_FAIL_MSG = 10;

    // how a phase fills the weight packs
    typedef enum int {
        WEIGHTS_RANDOM,
        WEIGHTS_FULL,
        WEIGHTS_NONE
    } t_weight_fill;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [PACK_W-1:0]    i_cfg_data;

    wwac_pix_if pix_if ();
    wwac_res_if res_if ();

    weighted_window_abs_contrast #(
        .WINDOW   (WIN),
        .MAX_LINE (MAX_LINE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // bench copy of the registers and of the filter state
    logic [LEN_CFG_W-1:0] len_reg;
    logic [PACK_W-1:0]    weight_reg [NPACK];
    bit   [PIX_W-1:0]     line_mem [WIN-1][MAX_LINE];
    bit   [PIX_W-1:0]     win_mem [WIN][WIN];
    int unsigned          col_pos;
    int unsigned          lines_done;

    t_pix_beat   pixel_backlog [$];
    t_res_beat   contrast_due [$];
    int unsigned beats_queued;
    int unsigned beats_taken;
    int unsigned fail_cnt;

    // idling control
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned idle_odds;    // 0 means no idling in this phase
    bit          quiet;
    bit          hold_armed;
    logic        hold_off;

    // line length as the block sees it: zero reads as one, clipped to the store depth
    function automatic int unsigned active_len();
        if (len_reg == '0)
            return 1;
        if (len_reg > MAX_LINE)
            return MAX_LINE;
        return len_reg;
    endfunction

    // advance the window by one pixel and queue the contrast beat it produces, if any
    task automatic predict_contrast(t_pix_beat beat);
        bit [PIX_W-1:0] col [WIN];
        int unsigned    len;
        int unsigned    pos;
        int unsigned    ctr;
        int unsigned    v;
        int unsigned    acc;
        t_res_beat      res;
        len = active_len();
        if (beat.frame_start) begin
            col_pos    = 0;
            lines_done = 0;
        end
        if (col_pos >= len)
            col_pos = 0;
        pos = col_pos;

        // new column: stored lines oldest first, the fresh pixel at the bottom
        for (int r = 0; r < WIN - 1; r++)
            col[r] = line_mem[r][pos];
        col[WIN-1] = beat.pixel;
        for (int r = 0; r < WIN - 1; r++)
            line_mem[r][pos] = col[r+1];

        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN - 1; c++)
                win_mem[r][c] = win_mem[r][c+1];
            win_mem[r][WIN-1] = col[r];
        end

        if (lines_done >= WIN - 1 && pos >= WIN - 1) begin
            // center counts even when zero, zero surround pixels do not
            ctr = win_mem[(WIN-1)/2][(WIN-1)/2];
            acc = 0;
            for (int k = 0; k < WIN * WIN; k++) begin
                v = win_mem[k/WIN][k%WIN];
                if (v != 0)
                    acc += ((v > ctr) ? v - ctr : ctr - v) * weight_reg[k/8][8*(k%8) +: 8];
            end
            res.contrast = acc[CONTRAST_W-1:0];
            res.line_end = (pos + 1 == len);
            contrast_due.push_back(res);
        end

        if (pos + 1 >= len) begin
            col_pos = 0;
            if (lines_done < WIN - 1)
                lines_done++;
        end else begin
            col_pos = pos + 1;
        end
    endtask

    task automatic check_result(t_res_beat got);
        t_res_beat want;
        if (contrast_due.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= MAX_FAIL_MSG)
                $display("unexpected result beat: contrast=%0d line_end=%0b",
                         got.contrast, got.line_end);
        end else begin
            want = contrast_due.pop_front();
            if (got.contrast !== want.contrast || got.line_end !== want.line_end) begin
                fail_cnt++;
                if (fail_cnt <= MAX_FAIL_MSG)
                    $display("result mismatch: contrast exp=%0d got=%0d, line_end exp=%0b got=%0b",
                             want.contrast, got.contrast, want.line_end, got.line_end);
            end
        end
    endtask

    // one register write, bench copy updated when the write is driven
    task automatic write_reg(t_cfg_idx idx, logic [PACK_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_LINE_LENGTH)
            len_reg = val[LEN_CFG_W-1:0];
        else
            weight_reg[int'(idx) - int'(CFG_WEIGHT_PACK_0)] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_weights(t_weight_fill fill);
        logic [PACK_W-1:0] val;
        for (int p = 0; p < NPACK; p++) begin
            case (fill)
                WEIGHTS_FULL: val = '1;
                WEIGHTS_NONE: val = '0;
                default: begin
                    // some zero weights mixed in; unused fields get noise
                    for (int b = 0; b < 8; b++)
                        val[8*b +: 8] = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom);
                end
            endcase
            write_reg(t_cfg_idx'(int'(CFG_WEIGHT_PACK_0) + p), val);
        end
    endtask

    // biased toward zero and the ends of the range
    function automatic logic [PIX_W-1:0] pick_pixel(int unsigned zero_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct)
            return '0;
        if (roll < zero_pct + 5)
            return '1;
        if (roll < zero_pct + 8)
            return 8'd1;
        return 8'($urandom);
    endfunction

    task automatic queue_pixel(logic [PIX_W-1:0] pix, logic fs);
        pixel_backlog.push_back(t_pix_beat'{pixel: pix, frame_start: fs});
        beats_queued++;
    endtask

    // a frame of whole lines plus a partial one; noisy frames get stray frame starts
    task automatic queue_frame(int unsigned lines, int unsigned extra,
                               int unsigned zero_pct, bit noisy);
        int unsigned n;
        n = lines * active_len() + extra;
        for (int unsigned i = 0; i < n; i++)
            queue_pixel(pick_pixel(zero_pct),
                        (i == 0) || (noisy && $urandom_range(0, 39) == 0));
    endtask

    // block empty: every beat taken, every result back, pipeline drained
    task automatic settle();
        wait (beats_taken == beats_queued);
        wait (contrast_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // pixel driver: holds a beat until taken, random gap bursts between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                predict_contrast(pix_if.data);
                beats_taken++;
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pix_if.valid <= 1'b0;
                end else if (pixel_backlog.size() == 0) begin
                    pix_if.valid <= 1'b0;
                end else if (!quiet && idle_odds != 0 &&
                             $urandom_range(0, idle_odds - 1) == 0) begin
                    gap_left = $urandom_range(0, 14);
                    pix_if.valid <= 1'b0;
                end else begin
                    pix_if.data  <= pixel_backlog.pop_front();
                    pix_if.valid <= 1'b1;
                end
            end
        end
    end

    // result monitor: checks every taken beat, stalls in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready)
                check_result(res_if.data);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (hold_off) begin
                res_if.ready <= 1'b0;
            end else if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                stall_left = $urandom_range(0, 14);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off once results flow, so the window fills and i_pix backs up
    initial begin
        hold_off = 1'b0;
        wait (hold_armed && res_if.valid);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #20000000;
        $display("[weighted_window_abs_contrast] ERROR");
        $finish;
    end

    initial begin
        int unsigned  start;
        int unsigned  len_pick;
        int unsigned  frames;
        int unsigned  roll;
        bit           first;
        t_weight_fill fill;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        res_if.ready = 1'b0;
        len_reg      = LEN_RESET;
        for (int p = 0; p < NPACK; p++)
            weight_reg[p] = '0;
        col_pos      = 0;
        lines_done   = 0;
        beats_queued = 0;
        beats_taken  = 0;
        fail_cnt     = 0;
        gap_left     = 0;
        stall_left   = 0;
        idle_odds    = 6;
        quiet        = 1'b0;
        hold_armed   = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // line length left at its reset value of MAX_LINE, a partial first line
        load_weights(WEIGHTS_RANDOM);
        queue_frame(0, 12, 15, 1'b0);
        settle();

        // directed 5x7 image, full weights: zero center under 255 surround gives the
        // largest sum, then an all-zero line, then a line of ones
        write_reg(CFG_LINE_LENGTH, 64'd5);
        load_weights(WEIGHTS_FULL);
        for (int ln = 0; ln < 7; ln++) begin
            for (int c = 0; c < 5; c++) begin
                if (ln == 2 && c == 2)
                    queue_pixel(8'd0, 1'b0);
                else if (ln == 5)
                    queue_pixel(8'd0, 1'b0);
                else if (ln == 6)
                    queue_pixel(8'd1, 1'b0);
                else
                    queue_pixel(8'd255, ln == 0 && c == 0);
            end
        end
        settle();

        // lines shorter than the window never give a result; zero acts as one
        write_reg(CFG_LINE_LENGTH, 64'd0);
        queue_frame(6, 3, 10, 1'b0);
        settle();
        write_reg(CFG_LINE_LENGTH, 64'd1);
        queue_frame(6, 3, 10, 1'b0);
        settle();
        write_reg(CFG_LINE_LENGTH, 64'(WIN - 1));
        queue_frame(6, 3, 10, 1'b0);
        settle();

        // largest register value, clipped to MAX_LINE
        write_reg(CFG_LINE_LENGTH, 64'd2047);
        load_weights(WEIGHTS_RANDOM);
        queue_frame(0, 8, 20, 1'b0);
        settle();

        // random phases: mostly well-formed frames, some broken ones
        hold_armed = 1'b1;
        first      = 1'b1;
        start      = beats_queued;
        while (beats_queued - start < RANDOM_BEATS) begin
            if (beats_queued - start >= RANDOM_BEATS - CALM_BEATS)
                quiet = 1'b1;
            if (first)
                len_pick = 12;
            else if ($urandom_range(0, 7) == 0)
                len_pick = $urandom_range(0, WIN - 1);
            else
                len_pick = $urandom_range(WIN, 24);
            write_reg(CFG_LINE_LENGTH, 64'(len_pick));

            roll = $urandom_range(0, 9);
            fill = (roll == 0) ? WEIGHTS_NONE : (roll == 1) ? WEIGHTS_FULL : WEIGHTS_RANDOM;
            load_weights(fill);

            roll = $urandom_range(0, 2);
            idle_odds = (roll == 0) ? 0 : (roll == 1) ? 3 : 8;

            frames = first ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if (!first && $urandom_range(0, 4) == 0)
                    queue_frame($urandom_range(0, WIN - 1), $urandom_range(0, 10), 20, 1'b1);
                else
                    queue_frame(first ? 10 : $urandom_range(WIN, WIN + 3),
                                $urandom_range(0, 3), $urandom_range(0, 40), 1'b0);
            end
            first = 1'b0;
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[weighted_window_abs_contrast] OK");
        else
            $display("[weighted_window_abs_contrast] ERROR");
        $finish;
    end

endmodule
